// File: hdl/bdc_pkg.sv
// shared types, register indexes and event codes for the button qualifier
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LVL = 2'd3;

    // register reset values
    localparam logic [15:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [15:0] LONG_PRESS_RST = 16'd800;
    localparam logic [15:0] CLICK_MAX_RST  = 16'd500;
    localparam logic        ACTIVE_LVL_RST = 1'b1;

    // item kinds
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    // event codes
    localparam logic [1:0] EV_LONG     = 2'd0;
    localparam logic [1:0] EV_PRESSED  = 2'd1;
    localparam logic [1:0] EV_RELEASED = 2'd2;
    localparam logic [1:0] EV_CLICK    = 2'd3;

    typedef struct packed {
        logic        func;
        logic [31:0] tick_ms;
        logic        pin_level;
    } item_t;

    typedef struct packed {
        logic [1:0] event_code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
        logic [15:0] click_max_time;
        logic        active_level;
    } cfg_t;

    // up to two events produced by one item, in order
    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] code0;
        logic [1:0] code1;
    } events_t;

endpackage

`default_nettype wire

// File: hdl/bdc_core.sv
// button state and event decision for one item
`timescale 1ns / 1ps
`default_nettype none

module bdc_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire bdc_pkg::item_t  item,
    input  wire bdc_pkg::cfg_t   cfg,
    input  wire logic [1:0]      space,
    output logic                 fire,
    output bdc_pkg::events_t     ev
);
    import bdc_pkg::*;

    logic        stable_pressed_reg;
    logic        edge_pending_reg;
    logic [31:0] edge_time_reg;
    logic [31:0] press_start_reg;
    logic        long_reported_reg;

    logic [31:0] held;
    logic [31:0] since_edge;
    logic        is_poll;
    logic        long_hit;
    logic        resolve;
    logic        pressed_now;
    logic        change;
    logic        click;
    logic [1:0]  n_item;

    assign is_poll    = (item.func == FUNC_POLL);
    assign held       = item.tick_ms - press_start_reg;
    assign since_edge = item.tick_ms - edge_time_reg;

    assign long_hit = stable_pressed_reg && !long_reported_reg
                      && (cfg.long_press_time != 16'd0)
                      && (held >= {16'd0, cfg.long_press_time});
    assign resolve     = edge_pending_reg && (since_edge >= {16'd0, cfg.debounce_time});
    assign pressed_now = (item.pin_level == cfg.active_level);
    assign change      = resolve && (pressed_now != stable_pressed_reg);
    assign click       = change && !pressed_now && (cfg.click_max_time != 16'd0)
                         && !(long_reported_reg || long_hit)
                         && (held <= {16'd0, cfg.click_max_time});

    always_comb begin
        n_item = 2'd0;
        if (is_poll) begin
            n_item = 2'({1'b0, long_hit}) + 2'({1'b0, change}) + 2'({1'b0, click});
        end
    end

    assign fire = in_valid && (n_item <= space);

    // order: long press, then press or release, then click
    always_comb begin
        ev.cnt   = fire ? n_item : 2'd0;
        ev.code0 = EV_LONG;
        ev.code1 = EV_CLICK;
        if (long_hit) begin
            ev.code0 = EV_LONG;
            ev.code1 = EV_RELEASED;
        end else if (change) begin
            ev.code0 = pressed_now ? EV_PRESSED : EV_RELEASED;
            ev.code1 = EV_CLICK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_pressed_reg <= 1'b0;
            edge_pending_reg   <= 1'b0;
            edge_time_reg      <= 32'd0;
            press_start_reg    <= 32'd0;
            long_reported_reg  <= 1'b0;
        end else if (fire) begin
            if (!is_poll) begin
                edge_pending_reg <= 1'b1;
                edge_time_reg    <= item.tick_ms;
            end else begin
                if (long_hit) begin
                    long_reported_reg <= 1'b1;
                end
                if (resolve) begin
                    edge_pending_reg <= 1'b0;
                end
                if (change) begin
                    stable_pressed_reg <= pressed_now;
                    if (pressed_now) begin
                        press_start_reg   <= item.tick_ms;
                        long_reported_reg <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/bdc_outq.sv
// two-entry result queue feeding the result channel
`timescale 1ns / 1ps
`default_nettype none

module bdc_outq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bdc_pkg::events_t  push,
    output logic [1:0]             space,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bdc_pkg::result_t       m_data
);
    import bdc_pkg::*;

    result_t    q0_reg, q1_reg;
    result_t    q0_next, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_d;
    logic       drain;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = q0_reg;
    assign drain   = m_valid && m_ready;
    assign cnt_d   = cnt_reg - 2'({1'b0, drain});
    assign space   = 2'd2 - cnt_d;

    always_comb begin
        q0_next  = drain ? q1_reg : q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_d + push.cnt;
        unique case (cnt_d)
            2'd0: begin
                if (push.cnt != 2'd0) begin
                    q0_next = '{event_code: push.code0, last: (push.cnt == 2'd1)};
                end
                if (push.cnt == 2'd2) begin
                    q1_next = '{event_code: push.code1, last: 1'b1};
                end
            end
            2'd1: begin
                if (push.cnt != 2'd0) begin
                    q1_next = '{event_code: push.code0, last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire

// File: hdl/button_debounce_click_detector.sv
// top level of the push button debounce, long press and click qualifier
// path: an accepted transaction is registered in the input stage, its results in the result queue that drives m_
// throughput: one transaction per cycle while the result queue has room for its results; a poll giving
//   two results takes both entries of the two-entry result queue
// reset: aresetn synchronous active low; registers return to defaults, button released,
//   input stage and result queue empty
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_click_detector (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input transactions: edge marks and polls
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire bdc_pkg::item_t                     s_data,
    // result transactions
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output bdc_pkg::result_t                        m_data,
    // register writes
    input  wire logic                               cfg_we,
    input  wire logic [bdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import bdc_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;

    // input stage: one transaction waiting for its decision
    logic    in_valid_reg;
    item_t   in_reg;

    logic    fire;
    logic [1:0] space;
    events_t ev;

    // take a new transaction when the stage is empty or its content moves on now
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // plain register writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time   <= DEBOUNCE_RST;
            cfg_reg.long_press_time <= LONG_PRESS_RST;
            cfg_reg.click_max_time  <= CLICK_MAX_RST;
            cfg_reg.active_level    <= ACTIVE_LVL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   cfg_reg.debounce_time   <= cfg_wdata;
                CFG_LONG_PRESS: cfg_reg.long_press_time <= cfg_wdata;
                CFG_CLICK_MAX:  cfg_reg.click_max_time  <= cfg_wdata;
                CFG_ACTIVE_LVL: cfg_reg.active_level    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // decision: waits only if the queue cannot hold this transaction's results
    bdc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .item     (in_reg),
        .cfg      (cfg_reg),
        .space    (space),
        .fire     (fire),
        .ev       (ev)
    );

    // result queue, parts the result port from the decision
    bdc_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (ev),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// File: hdl/bdc_checker.sv
// port-level checks for the button qualifier and their binding
`timescale 1ns / 1ps
`default_nettype none

module bdc_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire bdc_pkg::result_t  m_data
);
    import bdc_pkg::*;

    result_t prev_reg;

    // last result taken on the result port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '{event_code: EV_LONG, last: 1'b1};
        end else if (m_valid && m_ready) begin
            prev_reg <= m_data;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("result port not empty after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_click_after_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_code == EV_CLICK) |->
            (prev_reg.event_code == EV_RELEASED) && !prev_reg.last && m_data.last)
        else $error("click not directly after a release of the same transaction");

    a_not_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |->
            (m_data.event_code == EV_LONG) || (m_data.event_code == EV_RELEASED))
        else $error("only long press or release can be followed by another result");

endmodule

bind button_debounce_click_detector bdc_checker u_bdc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the push button debounce, long press and click qualifier
`timescale 1ns / 1ps

module tb_top;
    import bdc_pkg::*;

    localparam int unsigned ITEM_GOAL   = 1350;    // input transactions for the whole run
    localparam int unsigned PHASE_ITEMS = 331;     // random transactions per register setting
    localparam int unsigned LONG_HOLD   = 80;      // cycles the result side holds off once
    localparam int unsigned SETTLE      = 8;       // quiet cycles after the last expected event
    localparam int unsigned CYCLE_LIMIT = 200000;

    // tracks the button state alongside the block and holds the events still owed
    class button_scoreboard;
        // register copies
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
        logic [15:0] click_max_time;
        logic        active_level;
        // qualifier state
        logic        stable_pressed;
        logic        edge_pending;
        logic [31:0] edge_time;
        logic [31:0] press_start;
        logic        long_reported;
        // events predicted and not yet seen on the result port
        result_t     expected_events[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned polls;
        int unsigned seen[4];

        function new();
            debounce_time   = DEBOUNCE_RST;
            long_press_time = LONG_PRESS_RST;
            click_max_time  = CLICK_MAX_RST;
            active_level    = ACTIVE_LVL_RST;
            stable_pressed  = 1'b0;
            edge_pending    = 1'b0;
            edge_time       = '0;
            press_start     = '0;
            long_reported   = 1'b0;
            errors          = 0;
            checked         = 0;
            polls           = 0;
            foreach (seen[k]) seen[k] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE:   debounce_time   = val;
                CFG_LONG_PRESS: long_press_time = val;
                CFG_CLICK_MAX:  click_max_time  = val;
                CFG_ACTIVE_LVL: active_level    = val[0];
                default: ;
            endcase
        endfunction

        // advance the qualifier by one accepted transaction
        function void note_item(item_t it);
            result_t     evs[$];
            logic [31:0] held;
            logic [31:0] since_edge;
            logic        now_pressed;
            if (it.func == FUNC_EDGE) begin
                edge_pending = 1'b1;
                edge_time    = it.tick_ms;
                return;
            end
            polls++;
            held = it.tick_ms - press_start;
            if (stable_pressed && !long_reported && long_press_time != 16'd0 &&
                held >= {16'd0, long_press_time}) begin
                long_reported = 1'b1;
                evs.push_back('{event_code: EV_LONG, last: 1'b0});
            end
            since_edge = it.tick_ms - edge_time;
            if (edge_pending && since_edge >= {16'd0, debounce_time}) begin
                now_pressed  = (it.pin_level == active_level);
                edge_pending = 1'b0;
                if (now_pressed != stable_pressed) begin
                    stable_pressed = now_pressed;
                    if (now_pressed) begin
                        press_start   = it.tick_ms;
                        long_reported = 1'b0;
                        evs.push_back('{event_code: EV_PRESSED, last: 1'b0});
                    end else begin
                        evs.push_back('{event_code: EV_RELEASED, last: 1'b0});
                        if (click_max_time != 16'd0 && !long_reported &&
                            held <= {16'd0, click_max_time})
                            evs.push_back('{event_code: EV_CLICK, last: 1'b0});
                    end
                end
            end
            if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
            foreach (evs[k]) expected_events.push_back(evs[k]);
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_event(result_t got);
            result_t want;
            checked++;
            seen[got.event_code]++;
            if (expected_events.size() == 0) begin
                report($sformatf("event %0d with nothing outstanding", got.event_code));
                return;
            end
            want = expected_events.pop_front();
            if (got.event_code !== want.event_code)
                report($sformatf("event %0d: code %0d, wanted %0d",
                                 checked, got.event_code, want.event_code));
            if (got.last !== want.last)
                report($sformatf("event %0d: last %0b, wanted %0b",
                                 checked, got.last, want.last));
        endtask

        task finish_check();
            if (expected_events.size() != 0)
                report($sformatf("%0d events never arrived", expected_events.size()));
        endtask
    endclass

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    item_t   s_data;
    logic    m_valid;
    logic    m_ready;
    result_t m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    button_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    logic [31:0] tick;
    bit          idle_on      = 1'b1;   // random gaps on both sides
    bit          hold_request = 1'b0;   // asks the result side for one long hold-off
    bit          holding      = 1'b0;

    always #5 aclk = ~aclk;

    button_debounce_click_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // watchdog: a hung handshake or a missing event ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // monitor: values read here are the ones settled before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_item(s_data);
            if (m_valid && m_ready) sb.check_event(m_data);
        end
    end

    // result side: short random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                holding      = 1'b1;
                m_ready <= 1'b0;
                // count the hold-off cycle by cycle so the block backs up into its input
                for (int c = 0; c < LONG_HOLD; c++) @(posedge aclk);
                holding = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // offer one transaction and hold it until the block takes it
    task send_item(item_t it);
        if (idle_on && !holding && !hold_request && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        // no late-run idling on either side
        if (items_sent > ITEM_GOAL * 9 / 10) idle_on = 1'b0;
    endtask

    task offer(logic func, logic [31:0] t, logic pin);
        send_item('{func: func, tick_ms: t, pin_level: pin});
    endtask

    // let every owed event come out, then some quiet cycles since edge marks give none
    task settle();
        s_valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task write_all(logic [15:0] deb, logic [15:0] lng, logic [15:0] clk_max, logic lvl);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, lng);
        write_reg(CFG_CLICK_MAX, clk_max);
        // upper bits of the level write are don't-care
        write_reg(CFG_ACTIVE_LVL, {15'($urandom()), lvl});
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // tick advance scaled to the current register setting
    function automatic logic [31:0] tick_step();
        int unsigned r;
        int unsigned deb;
        int unsigned lng;
        int unsigned clk_max;
        r       = $urandom_range(0, 99);
        deb     = 32'(sb.debounce_time);
        lng     = 32'(sb.long_press_time);
        clk_max = 32'(sb.click_max_time);
        if (r < 10) return 32'd0;
        if (r < 45) return $urandom_range(0, deb + 2);
        if (r < 75) return $urandom_range(0, clk_max + clk_max / 4 + 2);
        if (r < 97) return $urandom_range(0, lng + lng / 4 + 2);
        return $urandom();   // jump anywhere, wraps the tick difference
    endfunction

    // bouncing edges then polls that mostly read the wanted level
    task press_sequence(bit want);
        logic lvl;
        int   n;
        lvl = want ? sb.active_level : ~sb.active_level;
        // one in five sequences has no edge mark at all
        if ($urandom_range(0, 4) != 0) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                offer(FUNC_EDGE, tick, 1'($urandom()));
                tick += $urandom_range(0, sb.debounce_time / 2 + 1);
            end
        end
        n = $urandom_range(1, 5);
        repeat (n) begin
            tick += tick_step();
            offer(FUNC_POLL, tick, ($urandom_range(0, 9) == 0) ? ~lvl : lvl);
        end
    endtask

    task random_phase(int unsigned goal);
        bit want;
        want = 1'($urandom_range(0, 1));
        tick = $urandom();
        while (items_sent < goal) begin
            if ($urandom_range(0, 6) == 0) begin
                // noise: any kind, any tick, any level
                offer(1'($urandom()), ($urandom_range(0, 1) ? $urandom() : tick),
                      1'($urandom()));
            end else begin
                press_sequence(want);
            end
            if ($urandom_range(0, 4) != 0) want = ~want;
        end
        settle();
    endtask

    function automatic logic [15:0] maybe_zero(int unsigned hi);
        return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, hi));
    endfunction

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed walk at reset settings: debounce 30, long 800, click 500, active high
        offer(FUNC_POLL, 32'd0, 1'b1);          // poll with nothing pending
        offer(FUNC_EDGE, 32'd0, 1'b0);          // pin ignored on an edge mark
        offer(FUNC_POLL, 32'd10, 1'b1);         // still bouncing
        offer(FUNC_POLL, 32'd30, 1'b1);         // debounce met exactly: pressed
        offer(FUNC_EDGE, 32'd100, 1'b1);
        offer(FUNC_POLL, 32'd140, 1'b0);        // short hold: released and click
        offer(FUNC_EDGE, 32'd200, 1'b0);
        offer(FUNC_POLL, 32'd240, 1'b1);        // pressed
        offer(FUNC_POLL, 32'd1040, 1'b1);       // held exactly the long time
        offer(FUNC_POLL, 32'd1100, 1'b1);       // long press only once
        offer(FUNC_EDGE, 32'd1100, 1'b0);
        offer(FUNC_POLL, 32'd1150, 1'b0);       // release after long press, no click
        offer(FUNC_EDGE, 32'd1200, 1'b1);
        offer(FUNC_POLL, 32'd1240, 1'b1);       // pressed
        offer(FUNC_EDGE, 32'd1300, 1'b0);
        offer(FUNC_POLL, 32'd2100, 1'b0);       // long press and release in one poll
        offer(FUNC_EDGE, 32'd2200, 1'b1);
        offer(FUNC_POLL, 32'd2240, 1'b0);       // settled but unchanged: nothing
        offer(FUNC_EDGE, 32'd2300, 1'b0);
        offer(FUNC_EDGE, 32'd2320, 1'b1);       // later edge restarts the debounce
        offer(FUNC_POLL, 32'd2340, 1'b1);       // too soon after the latest edge
        offer(FUNC_POLL, 32'd2350, 1'b1);       // pressed
        offer(FUNC_EDGE, 32'd2800, 1'b0);
        offer(FUNC_POLL, 32'd2850, 1'b0);       // hold equals click limit: click
        offer(FUNC_EDGE, 32'hFFFF_FFFF, 1'b1);  // edge at the top of the tick range
        offer(FUNC_POLL, 32'h0000_001E, 1'b1);  // tick wrapped, difference is 31
        settle();

        // all registers at their low extreme; the result side stalls for a long stretch
        write_all(16'd0, 16'd0, 16'd0, 1'b0);
        hold_request = 1'b1;
        random_phase(items_sent + PHASE_ITEMS);

        // all registers at their high extreme
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        random_phase(items_sent + PHASE_ITEMS);

        // moderate random timing
        write_all(16'($urandom_range(0, 80)), 16'($urandom_range(50, 1500)),
                  16'($urandom_range(1, 700)), 1'($urandom()));
        random_phase(items_sent + PHASE_ITEMS);

        // mixed: some features switched off at random
        write_all(maybe_zero(100), maybe_zero(2000), maybe_zero(1000), 1'($urandom()));
        random_phase(ITEM_GOAL);

        sb.finish_check();
        $display("tb: %0d transactions (%0d polls), %0d events checked", items_sent,
                 sb.polls, sb.checked);
        $display("tb: long %0d, pressed %0d, released %0d, click %0d over 5 settings",
                 sb.seen[EV_LONG], sb.seen[EV_PRESSED], sb.seen[EV_RELEASED],
                 sb.seen[EV_CLICK]);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/bdc_pkg.sv
hdl/bdc_core.sv
hdl/bdc_outq.sv
hdl/button_debounce_click_detector.sv
hdl/bdc_checker.sv
tb/tb_top.sv
